// File: design/lpht_pkg.sv
// Package for the linear-probe hash table: sizes, codes, beat structs, FSM states.
// No dependencies; imported by every module of the block.
package lpht_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int KEY_BITS    = 16;
    localparam int SLOT_BITS   = 7;
    localparam int CNT_BITS    = 8;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [1:0]          func;
        logic [KEY_BITS-1:0] key;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]           status;
        logic                 found;
        logic [SLOT_BITS-1:0] slot;
        logic [CNT_BITS-1:0]  compare_count;
    } t_out_beat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_DUP_RD,
        S_DUP_CMP,
        S_INS_CHK,
        S_INS_MOD,
        S_INS_PROBE,
        S_LK_MOD,
        S_LK_RD,
        S_LK_CMP,
        S_DEL_RD,
        S_DEL_CMP,
        S_SH_RD,
        S_SH_WR,
        S_RB_RD,
        S_RB_KEY,
        S_RB_MOD,
        S_RB_PROBE,
        S_DONE
    } t_state;

endpackage

// File: design/lpht_mod.sv
// Bit-serial restoring remainder unit: key mod table size, one key bit per cycle.
// Depends on lpht_pkg.
module lpht_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lpht_pkg::KEY_BITS-1:0] i_dividend,
    input  logic [lpht_pkg::CNT_BITS-1:0] i_divisor,
    output logic                          o_done,
    output logic [lpht_pkg::SLOT_BITS-1:0] o_rem
);
    import lpht_pkg::*;

    localparam int STEP_BITS = $clog2(KEY_BITS + 1);

    logic [KEY_BITS-1:0]  r_shift, n_shift;
    logic [CNT_BITS:0]    r_rem, n_rem;
    logic [CNT_BITS-1:0]  r_div, n_div;
    logic [STEP_BITS-1:0] r_step, n_step;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_BITS:0]    trial;

    always_comb begin
        n_shift = r_shift;
        n_rem   = r_rem;
        n_div   = r_div;
        n_step  = r_step;
        n_busy  = r_busy;
        n_done  = 1'b0;
        trial   = {r_rem[CNT_BITS-1:0], r_shift[KEY_BITS-1]};
        if (i_start) begin
            n_shift = i_dividend;
            n_rem   = '0;
            n_div   = i_divisor;
            n_step  = '0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_shift = {r_shift[KEY_BITS-2:0], 1'b0};
            n_rem   = (trial >= {1'b0, r_div}) ? trial - {1'b0, r_div} : trial;
            n_step  = r_step + 1'b1;
            if (r_step == STEP_BITS'(KEY_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_shift <= n_shift;
        r_rem   <= n_rem;
        r_div   <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[SLOT_BITS-1:0];

endmodule

// File: design/linear_probe_hash_table_top.sv
// Linear-probe hash table: sequencer, slot store, key list and valid bits.
// Depends on lpht_pkg and lpht_mod.
// Clear empties the valid bits and the key count; insert checks the key list for a duplicate, then probes;
// lookup probes from the home slot; delete scans and shifts the key list, then rebuilds the slots key by key.
// One item at a time: the key-mod-size unit and single memory ports set the pace.
// Reset (synchronous, active low): all slots empty, key count 0, table size 128, no output.
module linear_probe_hash_table_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lpht_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lpht_pkg::t_out_beat  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_data
);
    import lpht_pkg::*;

    t_state               r_state, n_state;
    logic [1:0]           r_func, n_func;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [CNT_BITS-1:0]  r_idx, n_idx;
    logic [SLOT_BITS-1:0] r_pos, n_pos;
    logic [CNT_BITS-1:0]  r_n, n_n;
    logic [CNT_BITS-1:0]  r_count, n_count;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    t_out_beat            r_out, n_out;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_size;

    logic [KEY_BITS-1:0]  kl_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]  st_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]  r_kl_q, r_st_q;
    logic                 kl_we, st_we;
    logic [SLOT_BITS-1:0] kl_waddr, kl_raddr;
    logic [KEY_BITS-1:0]  kl_wdata;

    logic                 mod_start, mod_done;
    logic [KEY_BITS-1:0]  mod_dividend;
    logic [SLOT_BITS-1:0] mod_rem;

    logic [CNT_BITS-1:0]  size;
    logic [SLOT_BITS-1:0] pos_next;
    logic [CNT_BITS-1:0]  idx_inc;

    assign size = (r_size == 8'd0) ? 8'd1 :
                  (r_size > CNT_BITS'(TABLE_DEPTH)) ? CNT_BITS'(TABLE_DEPTH) : r_size;
    // wrap from size-1 back to slot 0
    assign pos_next = ({1'b0, r_pos} + 8'd1 == size) ? '0 : r_pos + 1'b1;
    assign idx_inc  = r_idx + 1'b1;

    lpht_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_key        = r_key;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_n          = r_n;
        n_count      = r_count;
        n_valid      = r_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        kl_we        = 1'b0;
        kl_waddr     = r_count[SLOT_BITS-1:0];
        kl_wdata     = r_key;
        kl_raddr     = r_idx[SLOT_BITS-1:0];
        st_we        = 1'b0;
        mod_start    = 1'b0;
        mod_dividend = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_in_data.func;
                    n_key   = i_in_data.key;
                    n_idx   = '0;
                    n_out   = '0;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (r_func)
                    FUNC_INSERT: n_state = S_DUP_RD;
                    FUNC_LOOKUP: begin
                        mod_start = 1'b1;
                        n_state   = S_LK_MOD;
                    end
                    FUNC_DELETE: n_state = S_DEL_RD;
                    default: begin
                        n_valid = '0;
                        n_count = '0;
                        n_out.status = ST_DONE;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DUP_RD: n_state = (r_idx >= r_count) ? S_INS_CHK : S_DUP_CMP;
            S_DUP_CMP: begin
                if (r_kl_q == r_key) begin
                    n_out.status = ST_DUP;
                    n_state      = S_DONE;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_DUP_RD;
                end
            end
            S_INS_CHK: begin
                if (r_count >= size) begin
                    n_out.status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    mod_start = 1'b1;
                    n_state   = S_INS_MOD;
                end
            end
            S_INS_MOD: begin
                if (mod_done) begin
                    n_pos   = mod_rem;
                    n_n     = '0;
                    n_state = S_INS_PROBE;
                end
            end
            S_INS_PROBE: begin
                if (r_n >= size) begin
                    n_out.status = ST_FULL;
                    n_state      = S_DONE;
                end else if (!r_valid[r_pos]) begin
                    st_we          = 1'b1;
                    n_valid[r_pos] = 1'b1;
                    kl_we          = 1'b1;
                    n_count        = r_count + 1'b1;
                    n_out.slot     = r_pos;
                    n_out.status   = ST_DONE;
                    n_state        = S_DONE;
                end else begin
                    n_pos = pos_next;
                    n_n   = r_n + 1'b1;
                end
            end
            S_LK_MOD: begin
                if (mod_done) begin
                    n_pos   = mod_rem;
                    n_n     = '0;
                    n_state = S_LK_RD;
                end
            end
            S_LK_RD: begin
                if (r_n >= size) begin
                    n_out.status        = ST_ABSENT;
                    n_out.compare_count = r_n;
                    n_state             = S_DONE;
                end else begin
                    n_state = S_LK_CMP;
                end
            end
            S_LK_CMP: begin
                n_n = r_n + 1'b1;
                if (!r_valid[r_pos]) begin
                    n_out.status        = ST_ABSENT;
                    n_out.compare_count = n_n;
                    n_state             = S_DONE;
                end else if (r_st_q == r_key) begin
                    n_out.status        = ST_DONE;
                    n_out.found         = 1'b1;
                    n_out.slot          = r_pos;
                    n_out.compare_count = n_n;
                    n_state             = S_DONE;
                end else begin
                    n_pos   = pos_next;
                    n_state = S_LK_RD;
                end
            end
            S_DEL_RD: begin
                if (r_idx >= r_count) begin
                    n_out.status = ST_ABSENT;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_DEL_CMP;
                end
            end
            S_DEL_CMP: begin
                if (r_kl_q == r_key) begin
                    n_state = S_SH_RD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_DEL_RD;
                end
            end
            S_SH_RD: begin
                kl_raddr = idx_inc[SLOT_BITS-1:0];
                if (idx_inc >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_valid = '0;
                    n_idx   = '0;
                    n_state = S_RB_RD;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                kl_we    = 1'b1;
                kl_waddr = r_idx[SLOT_BITS-1:0];
                kl_wdata = r_kl_q;
                n_idx    = idx_inc;
                n_state  = S_SH_RD;
            end
            S_RB_RD: begin
                if (r_idx >= r_count) begin
                    n_out.status = ST_DONE;
                    n_out.found  = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_RB_KEY;
                end
            end
            S_RB_KEY: begin
                n_key        = r_kl_q;
                mod_dividend = r_kl_q;
                mod_start    = 1'b1;
                n_state      = S_RB_MOD;
            end
            S_RB_MOD: begin
                if (mod_done) begin
                    n_pos   = mod_rem;
                    n_n     = '0;
                    n_state = S_RB_PROBE;
                end
            end
            S_RB_PROBE: begin
                // a key with no free slot stays listed but unplaced
                if (r_n >= size) begin
                    n_idx   = idx_inc;
                    n_state = S_RB_RD;
                end else if (!r_valid[r_pos]) begin
                    st_we          = 1'b1;
                    n_valid[r_pos] = 1'b1;
                    n_idx          = idx_inc;
                    n_state        = S_RB_RD;
                end else begin
                    n_pos = pos_next;
                    n_n   = r_n + 1'b1;
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                if (r_out_valid && !i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_size      <= 8'd128;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
        end
        r_func <= n_func;
        r_key  <= n_key;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_n    <= n_n;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (kl_we) begin
            kl_mem[kl_waddr] <= kl_wdata;
        end
        r_kl_q <= kl_mem[kl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            st_mem[r_pos] <= r_key;
        end
        r_st_q <= st_mem[r_pos];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
